// ===== design/rsm_pkg.sv =====
// rsm_pkg: shared types and constants of the RC servo mapper with failsafe.
// No dependencies; every other file of the block but rsm_divider imports it.
`timescale 1ns / 1ps
`default_nettype none
package rsm_pkg;

  // Item commands
  localparam logic [1:0] CMD_CAPTURE = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_EXT     = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // Steering directions
  localparam logic [1:0] DIR_NEUTRAL = 2'd0;
  localparam logic [1:0] DIR_LEFT    = 2'd1;
  localparam logic [1:0] DIR_RIGHT   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_LEFT_THRESHOLD   = 3'd0;
  localparam logic [2:0] CFG_RIGHT_THRESHOLD  = 3'd1;
  localparam logic [2:0] CFG_INPUT_SPAN_LEFT  = 3'd2;
  localparam logic [2:0] CFG_INPUT_SPAN_RIGHT = 3'd3;
  localparam logic [2:0] CFG_SERVO_NEUTRAL    = 3'd4;
  localparam logic [2:0] CFG_SERVO_SPAN_LEFT  = 3'd5;
  localparam logic [2:0] CFG_SERVO_SPAN_RIGHT = 3'd6;
  localparam logic [2:0] CFG_TIMEOUT_START    = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_LEFT_THRESHOLD   = 16'd2900;
  localparam logic [15:0] RST_RIGHT_THRESHOLD  = 16'd3100;
  localparam logic [15:0] RST_INPUT_SPAN       = 16'd1000;
  localparam logic [15:0] RST_SERVO_NEUTRAL    = 16'd4500;
  localparam logic [15:0] RST_SERVO_SPAN       = 16'd1500;
  localparam logic [7:0]  RST_TIMEOUT_START    = 8'd20;

  // Servo limits and percent scale
  localparam logic [15:0] SERVO_LIMIT_LEFT  = 16'd3000;
  localparam logic [15:0] SERVO_LIMIT_RIGHT = 16'd6000;
  localparam logic [15:0] PERCENT_FULL      = 16'd100;

  // ceil(2^23 / 100): (x * PERCENT_RECIP) >> 23 equals x / 100 for any 16-bit x
  localparam logic [16:0] PERCENT_RECIP     = 17'd83887;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic div_load;  // set up operands and start the divider
    logic load_out;  // finish the item into the output register
  } rsm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;  // divider idle, quotient valid
  } rsm_sts_t;

endpackage
`default_nettype wire

// ===== design/rsm_divider.sv =====
// rsm_divider: restoring radix-2 divider, 32-bit dividend by 16-bit divisor.
// One quotient bit per cycle. Uses nothing from the package.
`timescale 1ns / 1ps
`default_nettype none
module rsm_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic [31:0]      quotient,
  output logic             done
);

  logic [31:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] den_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] shifted;
  logic        ge;

  // One shift and subtract step
  always_comb begin
    shifted  = {rem_r, quo_r[31]};
    ge       = (shifted >= {1'b0, den_r});
    rem_nxt  = ge ? 16'(shifted - {1'b0, den_r}) : shifted[15:0];
    quo_nxt  = {quo_r[30:0], ge};
    cnt_nxt  = cnt_r + 5'd1;
    busy_nxt = busy_r && (cnt_r != 5'd31);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd0;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= dividend;
      rem_r <= 16'd0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = !busy_r;

endmodule
`default_nettype wire

// ===== design/rsm_datapath.sv =====
// rsm_datapath: configuration registers, watchdog state, operand setup,
// final mapping and output register. Depends on rsm_pkg and rsm_divider.
`timescale 1ns / 1ps
`default_nettype none
module rsm_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rsm_pkg::rsm_cmd_t cmd,
  output rsm_pkg::rsm_sts_t     sts,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire logic [1:0]       in_command,
  input  wire logic [15:0]      in_pulse_width,
  input  wire logic [1:0]       in_steer_direction,
  input  wire logic [7:0]       in_steer_percent,
  output logic [14:0]           out_compare_value,
  output logic [1:0]            out_direction,
  output logic                  out_remote_active,
  output logic                  out_brake_request
);
  import rsm_pkg::*;

  // Configuration
  logic [15:0] left_thr_r, right_thr_r, in_span_l_r, in_span_r_r;
  logic [15:0] neutral_r, sv_span_l_r, sv_span_r_r;
  logic [7:0]  timeout_start_r;

  // Block state
  logic [15:0] stored_pulse_r;
  logic [7:0]  timeout_cnt_r;
  logic        remote_on_r;

  // Item working registers
  logic [1:0]  cmd_r;
  logic [1:0]  dir_r;
  logic [6:0]  pct_r;
  logic        ext_ok_r;
  logic        map_r;
  logic        brake_r;
  logic [9:0]  ext_step_r;

  // Setup signals
  logic [1:0]  region;
  logic [15:0] mul_a, mul_b;
  logic [31:0] dividend;
  logic [15:0] divisor;
  logic [31:0] quotient;
  logic        div_done;
  logic [15:0] ext_span;
  logic [32:0] ext_prod;

  // Finish signals
  logic signed [33:0] v_tick;
  logic signed [17:0] v_ext;
  logic [16:0]        ext_off;
  logic [15:0]        servo_tick, servo_ext, servo;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_thr_r      <= RST_LEFT_THRESHOLD;
      right_thr_r     <= RST_RIGHT_THRESHOLD;
      in_span_l_r     <= RST_INPUT_SPAN;
      in_span_r_r     <= RST_INPUT_SPAN;
      neutral_r       <= RST_SERVO_NEUTRAL;
      sv_span_l_r     <= RST_SERVO_SPAN;
      sv_span_r_r     <= RST_SERVO_SPAN;
      timeout_start_r <= RST_TIMEOUT_START;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_THRESHOLD:   left_thr_r      <= cfg_data;
        CFG_RIGHT_THRESHOLD:  right_thr_r     <= cfg_data;
        CFG_INPUT_SPAN_LEFT:  in_span_l_r     <= cfg_data;
        CFG_INPUT_SPAN_RIGHT: in_span_r_r     <= cfg_data;
        CFG_SERVO_NEUTRAL:    neutral_r       <= cfg_data;
        CFG_SERVO_SPAN_LEFT:  sv_span_l_r     <= cfg_data;
        CFG_SERVO_SPAN_RIGHT: sv_span_r_r     <= cfg_data;
        CFG_TIMEOUT_START:    timeout_start_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Capture and watchdog update at item accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_pulse_r <= 16'd0;
      timeout_cnt_r  <= 8'd0;
      remote_on_r    <= 1'b0;
    end else if (cmd.accept) begin
      if (in_command == CMD_CAPTURE) begin
        stored_pulse_r <= in_pulse_width;
        timeout_cnt_r  <= timeout_start_r;
      end else if (in_command == CMD_TICK) begin
        if (remote_on_r) begin
          if (timeout_cnt_r == 8'd0) begin
            remote_on_r <= 1'b0;
          end else begin
            timeout_cnt_r <= timeout_cnt_r - 8'd1;
          end
        end else if (timeout_cnt_r == timeout_start_r) begin
          remote_on_r <= 1'b1;
        end
      end
    end
  end

  // Per-item flags latched at accept; tick direction set from region at divider load
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r    <= in_command;
      pct_r    <= in_steer_percent[6:0];
      ext_ok_r <= (in_steer_percent <= PERCENT_FULL[7:0]);
      map_r    <= remote_on_r && (timeout_cnt_r != 8'd0);
      brake_r  <= (in_command == CMD_TICK) &&
                  (remote_on_r ? (timeout_cnt_r == 8'd0)
                               : (timeout_cnt_r == timeout_start_r));
      dir_r    <= in_steer_direction;
    end else if (cmd.div_load && (cmd_r == CMD_TICK)) begin
      dir_r    <= map_r ? region : DIR_NEUTRAL;
    end
  end

  // Pulse region against the thresholds
  always_comb begin
    if (stored_pulse_r > left_thr_r && stored_pulse_r < right_thr_r) begin
      region = DIR_NEUTRAL;
    end else if (stored_pulse_r > right_thr_r) begin
      region = DIR_RIGHT;
    end else if (stored_pulse_r < left_thr_r) begin
      region = DIR_LEFT;
    end else begin
      region = DIR_NEUTRAL;
    end
  end

  // Divider operands: servo span times pulse distance over input span
  always_comb begin
    if (region == DIR_RIGHT) begin
      mul_a   = sv_span_r_r;
      mul_b   = stored_pulse_r - right_thr_r;
      divisor = (in_span_r_r == 16'd0) ? 16'd1 : in_span_r_r;
    end else begin
      mul_a   = sv_span_l_r;
      mul_b   = left_thr_r - stored_pulse_r;
      divisor = (in_span_l_r == 16'd0) ? 16'd1 : in_span_l_r;
    end
    dividend = 32'(mul_a) * 32'(mul_b);
  end

  rsm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.div_load),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign sts.div_done = div_done;

  // Per-percent step of the servo span: span over 100 by reciprocal multiply
  always_comb begin
    ext_span = (dir_r == DIR_RIGHT) ? sv_span_r_r : sv_span_l_r;
    ext_prod = 33'(ext_span) * 33'(PERCENT_RECIP);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      ext_step_r <= ext_prod[32:23];
    end
  end

  // Tick value: neutral plus or minus offset, clamped to servo limits
  always_comb begin
    if (map_r && dir_r == DIR_RIGHT) begin
      v_tick = $signed({18'd0, neutral_r}) + $signed({2'b00, quotient});
    end else if (map_r && dir_r == DIR_LEFT) begin
      v_tick = $signed({18'd0, neutral_r}) - $signed({2'b00, quotient});
    end else begin
      v_tick = $signed({18'd0, neutral_r});
    end
    if (v_tick < $signed({18'd0, SERVO_LIMIT_LEFT})) begin
      servo_tick = SERVO_LIMIT_LEFT;
    end else if (v_tick > $signed({18'd0, SERVO_LIMIT_RIGHT})) begin
      servo_tick = SERVO_LIMIT_RIGHT;
    end else begin
      servo_tick = v_tick[15:0];
    end
  end

  // External value: truncated per-percent step times percent, saturated
  always_comb begin
    ext_off = 17'(ext_step_r) * 17'(pct_r);
    if (ext_ok_r && dir_r == DIR_RIGHT) begin
      v_ext = $signed({2'b00, neutral_r}) + $signed({1'b0, ext_off});
    end else if (ext_ok_r && dir_r == DIR_LEFT) begin
      v_ext = $signed({2'b00, neutral_r}) - $signed({1'b0, ext_off});
    end else begin
      v_ext = $signed({2'b00, neutral_r});
    end
    if (v_ext < 18'sd0) begin
      servo_ext = 16'd0;
    end else if (v_ext > 18'sd65535) begin
      servo_ext = 16'hFFFF;
    end else begin
      servo_ext = v_ext[15:0];
    end
    servo = (cmd_r == CMD_TICK) ? servo_tick : servo_ext;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_compare_value <= servo[15:1];
      out_direction     <= dir_r;
      out_remote_active <= remote_on_r;
      out_brake_request <= brake_r;
    end
  end

endmodule
`default_nettype wire

// ===== design/rsm_ctrl.sv =====
// rsm_ctrl: item sequencer and output handshake of the servo mapper.
// Depends on rsm_pkg for command codes and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none
module rsm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_command,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rsm_pkg::rsm_cmd_t     cmd,
  input  wire rsm_pkg::rsm_sts_t sts
);
  import rsm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.div_load = 1'b0;
    cmd.load_out = 1'b0;
    in_ready     = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == CMD_TICK || in_command == CMD_EXT) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when the item is taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== design/rc_servo_mapper_failsafe_core.sv =====
// RC servo mapper with failsafe: capture items update the stored pulse and the
// watchdog and give no result; tick and external items pass setup, the serial
// divider and finish into the output register; no new item is taken before that.
// The next item is accepted while a finished result waits in the output register.
// Synchronous active-low reset restores register defaults and clears the
// watchdog state. Depends on rsm_pkg, rsm_ctrl, rsm_datapath.
`timescale 1ns / 1ps
`default_nettype none
module rc_servo_mapper_failsafe_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Input item channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_pulse_width,
  input  wire logic [1:0]  in_steer_direction,
  input  wire logic [7:0]  in_steer_percent,
  // Result item channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]      out_compare_value,
  output logic [1:0]       out_direction,
  output logic             out_remote_active,
  output logic             out_brake_request
);
  import rsm_pkg::*;

  rsm_cmd_t cmd;
  rsm_sts_t sts;

  // Configuration is always writable
  assign cfg_ready = 1'b1;

  rsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rsm_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_command         (in_command),
    .in_pulse_width     (in_pulse_width),
    .in_steer_direction (in_steer_direction),
    .in_steer_percent   (in_steer_percent),
    .out_compare_value  (out_compare_value),
    .out_direction      (out_direction),
    .out_remote_active  (out_remote_active),
    .out_brake_request  (out_brake_request)
  );

endmodule
`default_nettype wire
